// ===== rtl/binned_variance_estimator_core_assert.svh =====
// Assertion macros shared by the estimator RTL, empty for synthesis
`ifndef BINNED_VARIANCE_ESTIMATOR_CORE_ASSERT_SVH
`define BINNED_VARIANCE_ESTIMATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define BVE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// pre in one cycle implies post in the next
`define BVE_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define BVE_ASSERT(lbl, prop, msg)
`define BVE_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== rtl/bve_pkg.sv =====
// Types and constants shared by the binned variance estimator modules
package bve_pkg;
	localparam int SAMPLE_W  = 32;
	localparam int SUM_W     = 64;
	localparam int BIN_ACC_W = 48;
	localparam int FILL_W    = 16;
	localparam int CFG_IDX_W = 1;
	localparam int DIV_W     = 64;
	localparam int DIV_CNT_W = 6;

	localparam logic [CFG_IDX_W-1:0] REG_KNOWN_MEAN      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_BIN = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ACCUM,
		ST_BIN_START,
		ST_BIN_DIV,
		ST_BIN_DEV,
		ST_BIN_SQUARE,
		ST_BIN_ACCUM,
		ST_PLAIN_START,
		ST_PLAIN_DIV,
		ST_VAR_START,
		ST_VAR_DIV,
		ST_WRITE
	} state_t;

	typedef enum logic [1:0] {
		DIV_BIN,
		DIV_PLAIN,
		DIV_VAR
	} div_sel_t;

	typedef struct packed {
		logic     capture;
		logic     square;
		logic     accum;
		logic     div_start;
		div_sel_t div_sel;
		logic     bin_dev;
		logic     bin_accum;
		logic     take_plain;
		logic     take_var;
		logic     load_out;
	} cmd_t;

	typedef struct packed {
		logic bin_close;
		logic last;
		logic var_skip;
		logic div_busy;
		logic div_done;
		logic out_free;
	} sts_t;
endpackage

// ===== rtl/bve_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle
`include "binned_variance_estimator_core_assert.svh"
module bve_div import bve_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);
	localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_W - 1);

	logic [DIV_W-1:0]     rem_q, quo_q, dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q, done_q;
	logic [DIV_W:0]       shifted, trial;
	logic                 fits;
	logic [DIV_W-1:0]     rem_next;

	always_comb begin
		shifted  = {rem_q, quo_q[DIV_W-1]};
		trial    = shifted - {1'b0, dsr_q};
		fits     = shifted >= {1'b0, dsr_q};
		rem_next = fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

	`BVE_ASSERT_NEXT(a_div_finish, busy_q && cnt_q == LAST_STEP, done_q && !busy_q, "div overrun")
endmodule

// ===== rtl/bve_ctrl.sv =====
// Sequencer: steps each sample through square and accumulate, then bin close and final divides where due
`include "binned_variance_estimator_core_assert.svh"
module bve_ctrl import bve_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_next  = ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				cmd.square = 1'b1;
				state_next = ST_ACCUM;
			end
			ST_ACCUM: begin
				cmd.accum = 1'b1;
				if (sts.bin_close)
					state_next = ST_BIN_START;
				else if (sts.last)
					state_next = ST_PLAIN_START;
				else
					state_next = ST_IDLE;
			end
			ST_BIN_START: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_BIN;
				state_next    = ST_BIN_DIV;
			end
			ST_BIN_DIV: begin
				if (sts.div_done)
					state_next = ST_BIN_DEV;
			end
			ST_BIN_DEV: begin
				cmd.bin_dev = 1'b1;
				state_next  = ST_BIN_SQUARE;
			end
			ST_BIN_SQUARE: begin
				cmd.square = 1'b1;
				state_next = ST_BIN_ACCUM;
			end
			ST_BIN_ACCUM: begin
				cmd.bin_accum = 1'b1;
				state_next    = sts.last ? ST_PLAIN_START : ST_IDLE;
			end
			ST_PLAIN_START: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_PLAIN;
				state_next    = ST_PLAIN_DIV;
			end
			ST_PLAIN_DIV: begin
				if (sts.div_done) begin
					cmd.take_plain = 1'b1;
					state_next     = sts.var_skip ? ST_WRITE : ST_VAR_START;
				end
			end
			ST_VAR_START: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_VAR;
				state_next    = ST_VAR_DIV;
			end
			ST_VAR_DIV: begin
				if (sts.div_done) begin
					cmd.take_var = 1'b1;
					state_next   = ST_WRITE;
				end
			end
			ST_WRITE: begin
				// wait for the result register to drain
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	`BVE_ASSERT(a_start_idle_div, cmd.div_start |-> !sts.div_busy, "divider started while busy")
	`BVE_ASSERT(a_ready_div_idle, in_ready |-> !sts.div_busy, "input taken while a divide runs")
	`BVE_ASSERT_NEXT(a_start_busy, cmd.div_start, sts.div_busy, "divider not busy after start")
endmodule

// ===== rtl/bve_dp.sv =====
// Datapath: config registers, squarer, saturating sums, bin counters, divider, result register
module bve_dp import bve_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write_en,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [SAMPLE_W-1:0]        cfg_data,
	input  logic signed [SAMPLE_W-1:0] sample_value,
	input  logic                       is_final,
	input  cmd_t                       cmd,
	output sts_t                       sts,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [SUM_W-1:0]           plain_variance,
	output logic [SUM_W-1:0]           bin_mean_var,
	output logic                       too_few_bins,
	output logic                       overflowed
);
	localparam int PAIR_W = (2 * COUNT_WIDTH > SUM_W) ? 2 * COUNT_WIDTH : SUM_W;

	function automatic logic [SAMPLE_W-1:0] abs_dev(input logic [SAMPLE_W-1:0] a,
			input logic [SAMPLE_W-1:0] b);
		logic [SAMPLE_W:0] d;
		logic [SAMPLE_W:0] nd;
		d  = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
		nd = -d;
		return d[SAMPLE_W] ? nd[SAMPLE_W-1:0] : d[SAMPLE_W-1:0];
	endfunction

	// configuration
	logic [SAMPLE_W-1:0] mean_q;
	logic [FILL_W-1:0]   spb_q;

	// per-item payload
	logic [SAMPLE_W-1:0] sample_q, mag_q;
	logic [SUM_W-1:0]    sq_q, plain_q, binv_q;
	logic                neg_q;

	// running state
	logic                  last_q, sat_q;
	logic [SUM_W-1:0]      dev_sum_q, bds_q;
	logic [BIN_ACC_W-1:0]  bin_acc_q;
	logic [FILL_W-1:0]     fill_q;
	logic [COUNT_WIDTH-1:0] total_q, bins_q;
	logic [PAIR_W-1:0]     pairs_q;

	// result register
	logic                out_valid_q, out_few_q, out_ovf_q;
	logic [SUM_W-1:0]    out_plain_q, out_bin_q;

	logic [FILL_W-1:0]    size, fill_next;
	logic [SUM_W:0]       dev_add, bds_add;
	logic [BIN_ACC_W-1:0] bin_acc_next, bin_mag;
	logic [SUM_W-1:0]     sq_next;
	logic [SAMPLE_W-1:0]  bmean;
	logic                 total_sat, bins_sat, few;
	logic [DIV_W-1:0]     div_dividend, div_divisor, quotient;
	logic                 div_busy, div_done;

	always_comb begin
		size         = (spb_q == '0) ? FILL_W'(1) : spb_q;
		fill_next    = fill_q + FILL_W'(1);
		dev_add      = {1'b0, dev_sum_q} + {1'b0, sq_q};
		bds_add      = {1'b0, bds_q} + {1'b0, sq_q};
		bin_acc_next = bin_acc_q + {{(BIN_ACC_W - SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q};
		bin_mag      = bin_acc_q[BIN_ACC_W-1] ? -bin_acc_q : bin_acc_q;
		sq_next      = SUM_W'(mag_q) * SUM_W'(mag_q);
		bmean        = neg_q ? -quotient[SAMPLE_W-1:0] : quotient[SAMPLE_W-1:0];
		total_sat    = &total_q;
		bins_sat     = &bins_q;
		few          = bins_q < COUNT_WIDTH'(2);
		case (cmd.div_sel)
			DIV_BIN: begin
				div_dividend = DIV_W'(bin_mag);
				div_divisor  = DIV_W'(size);
			end
			DIV_PLAIN: begin
				div_dividend = dev_sum_q;
				div_divisor  = DIV_W'(total_q);
			end
			DIV_VAR: begin
				div_dividend = bds_q;
				div_divisor  = pairs_q[DIV_W-1:0];
			end
			default: begin
				div_dividend = dev_sum_q;
				div_divisor  = DIV_W'(total_q);
			end
		endcase
	end

	bve_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quotient)
	);

	always_comb begin
		sts.bin_close = fill_next >= size;
		sts.last      = last_q;
		// Nb*(Nb-1) past 64 bits gives a zero binned variance
		sts.var_skip  = few || ((pairs_q >> SUM_W) != '0);
		sts.div_busy  = div_busy;
		sts.div_done  = div_done;
		sts.out_free  = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q <= '0;
			spb_q  <= FILL_W'(1);
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_KNOWN_MEAN:      mean_q <= cfg_data;
				REG_SAMPLES_PER_BIN: spb_q  <= cfg_data[FILL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= sample_value;
			mag_q    <= abs_dev(sample_value, mean_q);
		end else if (cmd.bin_dev) begin
			mag_q <= abs_dev(bmean, mean_q);
		end
		if (cmd.square)
			sq_q <= sq_next;
		if (cmd.div_start && cmd.div_sel == DIV_BIN)
			neg_q <= bin_acc_q[BIN_ACC_W-1];
		if (cmd.take_plain) begin
			plain_q <= quotient;
			binv_q  <= '0;
		end
		if (cmd.take_var)
			binv_q <= quotient;
		if (cmd.load_out) begin
			out_plain_q <= plain_q;
			out_bin_q   <= binv_q;
			out_few_q   <= few;
			out_ovf_q   <= sat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= 1'b0;
			sat_q     <= 1'b0;
			dev_sum_q <= '0;
			bds_q     <= '0;
			bin_acc_q <= '0;
			fill_q    <= '0;
			total_q   <= '0;
			bins_q    <= '0;
			pairs_q   <= '0;
		end else if (cmd.load_out) begin
			// data set delivered: start afresh
			sat_q     <= 1'b0;
			dev_sum_q <= '0;
			bds_q     <= '0;
			bin_acc_q <= '0;
			fill_q    <= '0;
			total_q   <= '0;
			bins_q    <= '0;
			pairs_q   <= '0;
		end else begin
			if (cmd.capture)
				last_q <= is_final;
			if (cmd.accum) begin
				dev_sum_q <= dev_add[SUM_W] ? '1 : dev_add[SUM_W-1:0];
				if (!total_sat)
					total_q <= total_q + COUNT_WIDTH'(1);
				if (dev_add[SUM_W] || total_sat)
					sat_q <= 1'b1;
				bin_acc_q <= bin_acc_next;
				fill_q    <= fill_next;
			end
			if (cmd.bin_accum) begin
				bds_q <= bds_add[SUM_W] ? '1 : bds_add[SUM_W-1:0];
				if (bds_add[SUM_W] || bins_sat)
					sat_q <= 1'b1;
				if (!bins_sat) begin
					bins_q  <= bins_q + COUNT_WIDTH'(1);
					// (n+1)*n = n*(n-1) + 2n
					pairs_q <= pairs_q + (PAIR_W'(bins_q) << 1);
				end
				bin_acc_q <= '0;
				fill_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign plain_variance = out_plain_q;
	assign bin_mean_var   = out_bin_q;
	assign too_few_bins   = out_few_q;
	assign overflowed     = out_ovf_q;
endmodule

// ===== rtl/binned_variance_estimator_core.sv =====
// Sample intake: a new sample is accepted only once the previous one has been squared and accumulated
// and, if it closed a bin, once the 64-step bin mean divide and the bin deviation update are done.
// Final sample: the result beat waits for two 64-step divides on the shared divider; with fewer than
// two full bins, or with the bin pair product Nb*(Nb-1) past 64 bits, the second divide is skipped.
// A waiting result beat does not block the next sample until another final one needs the register.
// Reset (arst_n low, asynchronous): all sums and counters cleared, known_mean 0, samples_per_bin 1.
module binned_variance_estimator_core import bve_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write_en,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [SAMPLE_W-1:0]        cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample_value,
	input  logic                       is_final,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [SUM_W-1:0]           plain_variance,
	output logic [SUM_W-1:0]           bin_mean_var,
	output logic                       too_few_bins,
	output logic                       overflowed
);
	cmd_t cmd;
	sts_t sts;

	bve_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bve_dp #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.sample_value   (sample_value),
		.is_final       (is_final),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.plain_variance (plain_variance),
		.bin_mean_var   (bin_mean_var),
		.too_few_bins   (too_few_bins),
		.overflowed     (overflowed)
	);
endmodule
